FILE: rtl/kshm_pkg.sv
// ----------------------------------------------------------------------------
// kshm_pkg
// Shared widths, status codes and the word passed from front end to back end.
// ----------------------------------------------------------------------------
package kshm_pkg;

	localparam int OUT_FRAC_BITS_DEF = 16;

	localparam int CW    = 12;
	localparam int DFW   = 13;
	localparam int SW    = 14;
	localparam int PW    = 28;
	localparam int NW    = 44;
	localparam int DENW  = 40;
	localparam int QBITS = 33;
	localparam int NDIV  = 9;
	localparam int QDEPTH = 4;

	localparam int INSET_MAX = 1000;
	localparam int MILLI     = 1000;
	localparam int DK_SCALE  = 2000;

	typedef enum logic [1:0] {
		ST_VALID = 2'd0,
		ST_RANGE = 2'd1,
		ST_DEGEN = 2'd2
	} status_t;

	typedef struct packed {
		logic [NDIV-1:0][NW-1:0] num;
		logic [DENW-1:0]         dk;
		logic [DENW-1:0]         d2;
		status_t                 status;
	} kshm_word_t;

endpackage

FILE: rtl/kshm_front.sv
// ----------------------------------------------------------------------------
// kshm_front
// Range check, corner mapping, projective solve and numerator build.
// ----------------------------------------------------------------------------
module kshm_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [kshm_pkg::CW-1:0]    inset_tl_x,
	input  logic signed [kshm_pkg::CW-1:0]    inset_tl_y,
	input  logic signed [kshm_pkg::CW-1:0]    inset_tr_x,
	input  logic signed [kshm_pkg::CW-1:0]    inset_tr_y,
	input  logic signed [kshm_pkg::CW-1:0]    inset_bl_x,
	input  logic signed [kshm_pkg::CW-1:0]    inset_bl_y,
	input  logic signed [kshm_pkg::CW-1:0]    inset_br_x,
	input  logic signed [kshm_pkg::CW-1:0]    inset_br_y,
	output logic                              word_valid,
	output kshm_pkg::kshm_word_t              word,
	input  logic                              word_stall
);
	import kshm_pkg::*;

	function automatic logic out_rng(input logic signed [CW-1:0] x);
		return (x < 0) || (x > INSET_MAX);
	endfunction

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic                  bad_s1, bad_s2;
	logic signed [CW-1:0]  c0x_s1, c0y_s1, c1x_s1, c1y_s1, c2x_s1, c2y_s1, c3x_s1, c3y_s1;
	logic signed [CW-1:0]  c0x_s2, c0y_s2, c1x_s2, c1y_s2, c2x_s2, c2y_s2;
	logic signed [CW-1:0]  c0x_s3, c0y_s3, c1x_s3, c1y_s3, c2x_s3, c2y_s3;
	logic signed [PW-1:0]  q_s2, gn_s2, hn_s2;
	logic signed [PW-1:0]  den_s3, hn_s3, gn_s3;
	status_t               st_s3, st_s4;
	logic signed [PW-1:0]  den_s4, hn_s4, gn_s4;
	logic signed [NW-1:0]  p0a_s4, p0b_s4, p1a_s4, p1b_s4, p4a_s4, p4b_s4, p5a_s4, p5b_s4;
	logic signed [NW-1:0]  p6_s4, p7_s4;
	logic [DENW-1:0]       dk_s4;
	kshm_word_t            word_s5;

	logic signed [DFW-1:0] dx03, dy23, dx23, dy03;
	logic signed [SW-1:0]  nn, dd;
	logic signed [NW-1:0]  k0, k1, k4, k5;

	assign adv        = !(vld_s5 && word_stall);
	assign in_stall   = !adv;
	assign word_valid = vld_s5;
	assign word       = word_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_comb begin
		dx03 = DFW'(c0x_s1) - DFW'(c3x_s1);
		dy23 = DFW'(c2y_s1) - DFW'(c3y_s1);
		dx23 = DFW'(c2x_s1) - DFW'(c3x_s1);
		dy03 = DFW'(c0y_s1) - DFW'(c3y_s1);
		nn   = SW'(c1x_s1) + SW'(c3x_s1) - SW'(c2x_s1) - SW'(c0x_s1);
		dd   = SW'(c1y_s1) + SW'(c3y_s1) - SW'(c2y_s1) - SW'(c0y_s1);
	end

	always_comb begin
		k0 = p0a_s4 + p0b_s4;
		k1 = p1a_s4 + p1b_s4;
		k4 = p4a_s4 + p4b_s4;
		k5 = p5a_s4 + p5b_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s1 <= out_rng(inset_tl_x) || out_rng(inset_tl_y) ||
				out_rng(inset_tr_x) || out_rng(inset_tr_y) ||
				out_rng(inset_bl_x) || out_rng(inset_bl_y) ||
				out_rng(inset_br_x) || out_rng(inset_br_y);
			c0x_s1 <= CW'(2 * inset_bl_x - MILLI);
			c0y_s1 <= CW'(MILLI - 2 * inset_bl_y);
			c1x_s1 <= CW'(2 * inset_tl_x - MILLI);
			c1y_s1 <= CW'(2 * inset_tl_y - MILLI);
			c2x_s1 <= CW'(MILLI - 2 * inset_tr_x);
			c2y_s1 <= CW'(2 * inset_tr_y - MILLI);
			c3x_s1 <= CW'(MILLI - 2 * inset_br_x);
			c3y_s1 <= CW'(MILLI - 2 * inset_br_y);

			bad_s2 <= bad_s1;
			q_s2   <= PW'(dx03) * PW'(dy23) - PW'(dx23) * PW'(dy03);
			gn_s2  <= PW'(dx23) * PW'(dd) - PW'(nn) * PW'(dy23);
			hn_s2  <= PW'(dx03) * PW'(dd) - PW'(nn) * PW'(dy03);
			c0x_s2 <= c0x_s1;
			c0y_s2 <= c0y_s1;
			c1x_s2 <= c1x_s1;
			c1y_s2 <= c1y_s1;
			c2x_s2 <= c2x_s1;
			c2y_s2 <= c2y_s1;

			if (bad_s2)
				st_s3 <= ST_RANGE;
			else if (q_s2 == '0)
				st_s3 <= ST_DEGEN;
			else
				st_s3 <= ST_VALID;
			den_s3 <= (q_s2 < 0) ? -q_s2 : q_s2;
			hn_s3  <= (q_s2 < 0) ? -hn_s2 : hn_s2;
			gn_s3  <= (q_s2 < 0) ? gn_s2 : -gn_s2;
			c0x_s3 <= c0x_s2;
			c0y_s3 <= c0y_s2;
			c1x_s3 <= c1x_s2;
			c1y_s3 <= c1y_s2;
			c2x_s3 <= c2x_s2;
			c2y_s3 <= c2y_s2;

			st_s4  <= st_s3;
			den_s4 <= den_s3;
			hn_s4  <= hn_s3;
			gn_s4  <= gn_s3;
			p0a_s4 <= NW'(DFW'(c2x_s3) - DFW'(c1x_s3)) * NW'(den_s3);
			p0b_s4 <= NW'(c2x_s3) * NW'(hn_s3);
			p1a_s4 <= NW'(DFW'(c2y_s3) - DFW'(c1y_s3)) * NW'(den_s3);
			p1b_s4 <= NW'(c2y_s3) * NW'(hn_s3);
			p4a_s4 <= NW'(DFW'(c0x_s3) - DFW'(c1x_s3)) * NW'(den_s3);
			p4b_s4 <= NW'(c0x_s3) * NW'(gn_s3);
			p5a_s4 <= NW'(DFW'(c0y_s3) - DFW'(c1y_s3)) * NW'(den_s3);
			p5b_s4 <= NW'(c0y_s3) * NW'(gn_s3);
			p6_s4  <= NW'(c1x_s3) * NW'(den_s3);
			p7_s4  <= NW'(c1y_s3) * NW'(den_s3);
			dk_s4  <= DENW'(NW'(den_s3) * DK_SCALE);

			word_s5.num[0] <= k0;
			word_s5.num[1] <= k1;
			word_s5.num[2] <= NW'(hn_s4);
			word_s5.num[3] <= k4;
			word_s5.num[4] <= k5;
			word_s5.num[5] <= NW'(gn_s4);
			word_s5.num[6] <= k0 + k4 + (p6_s4 <<< 1);
			word_s5.num[7] <= k1 + k5 + (p7_s4 <<< 1);
			word_s5.num[8] <= NW'(hn_s4) + NW'(gn_s4) + (NW'(den_s4) <<< 1);
			word_s5.dk     <= dk_s4;
			word_s5.d2     <= DENW'(NW'(den_s4) <<< 1);
			word_s5.status <= st_s4;
		end
	end

endmodule

FILE: rtl/kshm_queue.sv
// ----------------------------------------------------------------------------
// kshm_queue
// Short first-in first-out queue of words between front end and back end.
// ----------------------------------------------------------------------------
module kshm_queue #(
	parameter int DEPTH = kshm_pkg::QDEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	output logic                 wr_stall,
	input  kshm_pkg::kshm_word_t wr_word,
	output logic                 rd_valid,
	input  logic                 rd_stall,
	output kshm_pkg::kshm_word_t rd_word
);
	import kshm_pkg::*;

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	kshm_word_t        slot_q [DEPTH];
	logic [PTRW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]   cnt_q;
	logic              push, pop;

	assign wr_stall = (cnt_q == CNTW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_word  = slot_q[rd_ptr_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: rtl/kshm_div.sv
// ----------------------------------------------------------------------------
// kshm_div
// Pipelined restoring divider, one quotient bit a stage, rounded and clamped.
// ----------------------------------------------------------------------------
module kshm_div #(
	parameter int OUT_FRAC_BITS = kshm_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [kshm_pkg::NW-1:0]     num,
	input  logic        [kshm_pkg::DENW-1:0]   den,
	output logic signed [31:0]                 res
);
	import kshm_pkg::*;

	localparam int DW = NW + OUT_FRAC_BITS + 1;
	localparam int HW = DW - QBITS;

	logic [DENW-1:0]  rem_s  [QBITS+1];
	logic [QBITS-1:0] lo_s   [QBITS+1];
	logic [QBITS-1:0] quo_s  [QBITS+1];
	logic [DENW-1:0]  den_s  [QBITS+1];
	logic             neg_s  [QBITS+1];
	logic             sat_s  [QBITS+1];

	logic              neg;
	logic [NW-1:0]     mag;
	logic [DW-1:0]     dvd;
	logic [HW+DENW-1:0] hi_ext, den_ext;
	logic [QBITS-1:0]  rnd;
	logic [QBITS:0]    rnd_sum;

	always_comb begin
		neg     = num[NW-1];
		mag     = neg ? NW'(-num) : NW'(num);
		dvd     = DW'(mag) << (OUT_FRAC_BITS + 1);
		hi_ext  = {{DENW{1'b0}}, dvd[DW-1:QBITS]};
		den_ext = {{HW{1'b0}}, den};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= hi_ext[DENW-1:0];
			lo_s[0]  <= dvd[QBITS-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= neg;
			sat_s[0] <= (hi_ext >= den_ext);
		end
	end

	for (genvar k = 1; k <= QBITS; k++) begin : g_step
		logic [DENW:0] t;
		logic          ge;
		assign t  = {rem_s[k-1], lo_s[k-1][QBITS-1]};
		assign ge = (t >= {1'b0, den_s[k-1]});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DENW'(t - {1'b0, den_s[k-1]}) : t[DENW-1:0];
				lo_s[k]  <= lo_s[k-1] << 1;
				quo_s[k] <= {quo_s[k-1][QBITS-2:0], ge};
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	always_comb begin
		rnd_sum = {1'b0, quo_s[QBITS]} + 1'b1;
		rnd     = rnd_sum[QBITS:1];
		if (!neg_s[QBITS]) begin
			if (sat_s[QBITS] || rnd > 33'h0_7FFF_FFFF)
				res = 32'sh7FFF_FFFF;
			else
				res = signed'(rnd[31:0]);
		end else begin
			if (sat_s[QBITS] || rnd > 33'h0_8000_0000)
				res = 32'sh8000_0000;
			else
				res = signed'(-rnd[31:0]);
		end
	end

endmodule

FILE: rtl/kshm_back.sv
// ----------------------------------------------------------------------------
// kshm_back
// Nine dividers in lockstep, status alignment and the output register.
// ----------------------------------------------------------------------------
module kshm_back #(
	parameter int OUT_FRAC_BITS = kshm_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 word_valid,
	output logic                 word_stall,
	input  kshm_pkg::kshm_word_t word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   k_col0_x,
	output logic signed [31:0]   k_col0_y,
	output logic signed [31:0]   k_col0_w,
	output logic signed [31:0]   k_col1_x,
	output logic signed [31:0]   k_col1_y,
	output logic signed [31:0]   k_col1_w,
	output logic signed [31:0]   k_col3_x,
	output logic signed [31:0]   k_col3_y,
	output logic signed [31:0]   k_col3_w,
	output logic [1:0]           status
);
	import kshm_pkg::*;

	localparam int LAT = QBITS + 1;

	logic               adv;
	logic               vld_s [LAT];
	status_t            st_s  [LAT];
	logic signed [31:0] div_res [NDIV];
	logic signed [31:0] res_q   [NDIV];
	logic               out_valid_q;
	status_t            status_q;

	assign adv        = !out_valid_q || !out_stall;
	assign word_stall = !adv;

	for (genvar i = 0; i < NDIV; i++) begin : g_div
		kshm_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div (
			.clk (clk),
			.en  (adv),
			.num (word.num[i]),
			.den ((i % 3 == 2) ? word.d2 : word.dk),
			.res (div_res[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < LAT; j++)
				vld_s[j] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= word_valid;
			for (int j = 1; j < LAT; j++)
				vld_s[j] <= vld_s[j-1];
			out_valid_q <= vld_s[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0] <= word.status;
			for (int j = 1; j < LAT; j++)
				st_s[j] <= st_s[j-1];
			status_q <= st_s[LAT-1];
			for (int j = 0; j < NDIV; j++)
				res_q[j] <= (st_s[LAT-1] == ST_VALID) ? div_res[j] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign k_col0_x  = res_q[0];
	assign k_col0_y  = res_q[1];
	assign k_col0_w  = res_q[2];
	assign k_col1_x  = res_q[3];
	assign k_col1_y  = res_q[4];
	assign k_col1_w  = res_q[5];
	assign k_col3_x  = res_q[6];
	assign k_col3_y  = res_q[7];
	assign k_col3_w  = res_q[8];
	assign status    = status_q;

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_VALID |->
			res_q[0] == '0 && res_q[4] == '0 && res_q[8] == '0)
		else $error("fault word carries non-zero entries");

	a_tail_loads: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s[LAT-1] |=> out_valid_q)
		else $error("finished word not loaded into output register");

	a_tail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !vld_s[LAT-1] |=> !out_valid_q)
		else $error("output register loaded from empty stage");

endmodule

FILE: rtl/keystone_homography_matrix_top.sv
// Path of an accepted word to its result: five front stages, the queue,
// the divider stages and then the output register.
// Throughput: one word per cycle when nothing stalls; the front end, queue and
// divider pipeline each advance unless stalled, and the nine dividers retire one quotient bit a stage.
// A stall on the output holds the back end; the four-entry queue lets the
// front end keep accepting until it fills.
// Reset (arst_n low) empties every stage and the queue; no result is pending.
// ----------------------------------------------------------------------------
// keystone_homography_matrix_top
// Corner insets to keystone warp matrix entries, Q16.16 by default.
// ----------------------------------------------------------------------------
module keystone_homography_matrix_top #(
	parameter int OUT_FRAC_BITS = kshm_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [kshm_pkg::CW-1:0]  inset_tl_x,
	input  logic signed [kshm_pkg::CW-1:0]  inset_tl_y,
	input  logic signed [kshm_pkg::CW-1:0]  inset_tr_x,
	input  logic signed [kshm_pkg::CW-1:0]  inset_tr_y,
	input  logic signed [kshm_pkg::CW-1:0]  inset_bl_x,
	input  logic signed [kshm_pkg::CW-1:0]  inset_bl_y,
	input  logic signed [kshm_pkg::CW-1:0]  inset_br_x,
	input  logic signed [kshm_pkg::CW-1:0]  inset_br_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [31:0]              k_col0_x,
	output logic signed [31:0]              k_col0_y,
	output logic signed [31:0]              k_col0_w,
	output logic signed [31:0]              k_col1_x,
	output logic signed [31:0]              k_col1_y,
	output logic signed [31:0]              k_col1_w,
	output logic signed [31:0]              k_col3_x,
	output logic signed [31:0]              k_col3_y,
	output logic signed [31:0]              k_col3_w,
	output logic [1:0]                      status
);
	import kshm_pkg::*;

	logic       fe_valid, fe_stall, be_valid, be_stall;
	kshm_word_t fe_word, be_word;

	kshm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.inset_tl_x (inset_tl_x),
		.inset_tl_y (inset_tl_y),
		.inset_tr_x (inset_tr_x),
		.inset_tr_y (inset_tr_y),
		.inset_bl_x (inset_bl_x),
		.inset_bl_y (inset_bl_y),
		.inset_br_x (inset_br_x),
		.inset_br_y (inset_br_y),
		.word_valid (fe_valid),
		.word       (fe_word),
		.word_stall (fe_stall)
	);

	kshm_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fe_valid),
		.wr_stall (fe_stall),
		.wr_word  (fe_word),
		.rd_valid (be_valid),
		.rd_stall (be_stall),
		.rd_word  (be_word)
	);

	kshm_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (be_valid),
		.word_stall (be_stall),
		.word       (be_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.k_col0_x   (k_col0_x),
		.k_col0_y   (k_col0_y),
		.k_col0_w   (k_col0_w),
		.k_col1_x   (k_col1_x),
		.k_col1_y   (k_col1_y),
		.k_col1_w   (k_col1_w),
		.k_col3_x   (k_col3_x),
		.k_col3_y   (k_col3_y),
		.k_col3_w   (k_col3_w),
		.status     (status)
	);

endmodule

FILE: tb/sv/tb_keystone_homography_matrix_top.sv
// ----------------------------------------------------------------------------
// tb_keystone_homography_matrix_top
// Drives corner inset words through the keystone matrix block under random
// idling on both channels, predicts each matrix word in exact integer
// arithmetic and compares every field of every result in order.
// ----------------------------------------------------------------------------
module tb_keystone_homography_matrix_top;
	import kshm_pkg::*;

	localparam int FRAC = OUT_FRAC_BITS_DEF;

	typedef struct {
		logic signed [31:0] k [9];
		status_t            st;
	} matrix_t;

	typedef struct {
		int      ins [8];
		bit      known;
		matrix_t m;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [CW-1:0] inset_tl_x = 0, inset_tl_y = 0, inset_tr_x = 0, inset_tr_y = 0;
	logic signed [CW-1:0] inset_bl_x = 0, inset_bl_y = 0, inset_br_x = 0, inset_br_y = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] k_col0_x, k_col0_y, k_col0_w, k_col1_x, k_col1_y, k_col1_w;
	logic signed [31:0] k_col3_x, k_col3_y, k_col3_w;
	logic [1:0] status;

	matrix_t pending_matrices [$];
	int mismatches = 0;
	int send_idle = 10;
	int recv_idle = 72;
	row_t rows [$];

	keystone_homography_matrix_top dut (.*);

	always #2 clk = ~clk;

	function automatic logic signed [31:0] round_div(longint num, longint den);
		bit neg;
		longint un, q, r, mag;
		neg = num < 0;
		un = neg ? -num : num;
		q = un / den;
		r = un % den;
		if (q > (longint'(1) << (31 - FRAC)))
			mag = longint'(1) << 32;
		else begin
			mag = q;
			for (int i = 0; i < FRAC; i++) begin
				r = r << 1;
				mag = mag << 1;
				if (r >= den) begin
					r -= den;
					mag |= 1;
				end
			end
			if (2 * r >= den)
				mag++;
		end
		if (!neg)
			return (mag > 64'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
		if (mag > 64'h80000000)
			mag = 64'h80000000;
		return -mag[31:0];
	endfunction

	function automatic matrix_t solve_keystone(int v [8]);
		matrix_t m;
		longint c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;
		longint a, b, n, d, gn, hn, q, den, hh, gg, dk, k0, k1, k4, k5;
		foreach (m.k[i])
			m.k[i] = 0;
		m.st = ST_VALID;
		foreach (v[i])
			if (v[i] < 0 || v[i] > INSET_MAX) begin
				m.st = ST_RANGE;
				return m;
			end
		c0x = 2 * v[4] - MILLI;  c0y = MILLI - 2 * v[5];
		c1x = 2 * v[0] - MILLI;  c1y = 2 * v[1] - MILLI;
		c2x = MILLI - 2 * v[2];  c2y = 2 * v[3] - MILLI;
		c3x = MILLI - 2 * v[6];  c3y = MILLI - 2 * v[7];
		a = (c0x - c3x) * (c2y - c3y);
		b = (c2x - c3x) * (c0y - c3y);
		n = c1x + (c3x - c2x) - c0x;
		d = c1y + (c3y - c2y) - c0y;
		gn = (c2x - c3x) * d - n * (c2y - c3y);
		hn = (c0x - c3x) * d - n * (c0y - c3y);
		q = a - b;
		if (q == 0) begin
			m.st = ST_DEGEN;
			return m;
		end
		if (q > 0) begin
			den = q; hh = hn; gg = -gn;
		end else begin
			den = -q; hh = -hn; gg = gn;
		end
		dk = DK_SCALE * den;
		k0 = (c2x - c1x) * den + c2x * hh;
		k1 = (c2y - c1y) * den + c2y * hh;
		k4 = (c0x - c1x) * den + c0x * gg;
		k5 = (c0y - c1y) * den + c0y * gg;
		m.k[0] = round_div(k0, dk);
		m.k[1] = round_div(k1, dk);
		m.k[2] = round_div(hh, 2 * den);
		m.k[3] = round_div(k4, dk);
		m.k[4] = round_div(k5, dk);
		m.k[5] = round_div(gg, 2 * den);
		m.k[6] = round_div(k0 + k4 + 2 * c1x * den, dk);
		m.k[7] = round_div(k1 + k5 + 2 * c1y * den, dk);
		m.k[8] = round_div(hh + gg + 2 * den, 2 * den);
		return m;
	endfunction

	function automatic matrix_t zero_matrix(status_t st);
		matrix_t m;
		foreach (m.k[i])
			m.k[i] = 0;
		m.st = st;
		return m;
	endfunction

	task automatic add_row(int a0, a1, a2, a3, a4, a5, a6, a7, bit known = 0,
			status_t st = ST_VALID);
		row_t r;
		r.ins = '{a0, a1, a2, a3, a4, a5, a6, a7};
		r.known = known;
		r.m = zero_matrix(st);
		rows.push_back(r);
	endtask

	task automatic send_word(int v [8], matrix_t m);
		while (($urandom % 100) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		{inset_tl_x, inset_tl_y, inset_tr_x, inset_tr_y} <= {12'(v[0]), 12'(v[1]), 12'(v[2]),
			12'(v[3])};
		{inset_bl_x, inset_bl_y, inset_br_x, inset_br_y} <= {12'(v[4]), 12'(v[5]), 12'(v[6]),
			12'(v[7])};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_matrices.push_back(m);
	endtask

	function automatic int rand_inset();
		int p;
		p = $urandom_range(0, 99);
		if (p < 3)
			return $urandom_range(0, 4095) - 2048;
		if (p < 10)
			return $urandom_range(0, 1) ? 1000 : 0;
		if (p < 20)
			return 500;
		return $urandom_range(0, 1000);
	endfunction

	always @(posedge clk) begin
		matrix_t e;
		logic signed [31:0] got [9];
		out_stall <= (($urandom % 100) < recv_idle);
		if (arst_n && out_valid && !out_stall) begin
			got = '{k_col0_x, k_col0_y, k_col0_w, k_col1_x, k_col1_y, k_col1_w,
				k_col3_x, k_col3_y, k_col3_w};
			if (pending_matrices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word, status %0d", status);
			end else begin
				e = pending_matrices.pop_front();
				if (status !== e.st || got != e.k) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: status exp %0d got %0d", e.st, status);
						foreach (got[i])
							$display("  k[%0d] exp %0d got %0d", i, e.k[i], got[i]);
					end
				end
			end
		end
	end

	initial begin
		#4000000;
		$display("tb_keystone_homography_matrix_top failed");
		$finish;
	end

	initial begin
		int v [8];
		matrix_t m;
		int waited;
		add_row(0, 0, 0, 0, 0, 0, 0, 0);
		add_row(1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000);
		add_row(500, 500, 500, 500, 500, 500, 500, 500, 1, ST_DEGEN);
		add_row(250, 250, 250, 250, 250, 250, 250, 250);
		add_row(-1, 0, 0, 0, 0, 0, 0, 0, 1, ST_RANGE);
		add_row(0, 0, 0, 0, 0, 0, 0, 1001, 1, ST_RANGE);
		add_row(-2048, 2047, -2048, 2047, -2048, 2047, -2048, 2047, 1, ST_RANGE);
		add_row(2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 1, ST_RANGE);
		add_row(-1, -1, -1, -1, -1, -1, -1, -1, 1, ST_RANGE);
		add_row(0, 0, 0, 0, 0, 0, 0, -2048, 1, ST_RANGE);
		add_row(1000, 0, 0, 1000, 0, 1000, 1000, 0);
		add_row(0, 1000, 1000, 0, 1000, 0, 0, 1000);
		add_row(100, 0, 100, 0, 0, 0, 0, 0);
		add_row(0, 0, 0, 0, 499, 499, 500, 500);
		add_row(1000, 1000, 0, 0, 0, 0, 1000, 1000);
		add_row(999, 1, 1, 999, 1, 999, 999, 1);
		add_row(1000, 1000, 1000, 1000, 0, 0, 0, 0);
		add_row(0, 0, 0, 0, 1000, 1000, 1000, 1000);
		add_row(499, 500, 500, 501, 500, 500, 501, 499);
		add_row(1024, 0, 0, 0, 0, 0, 0, 0, 1, ST_RANGE);

		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i]) begin
			m = rows[i].known ? rows[i].m : solve_keystone(rows[i].ins);
			send_word(rows[i].ins, m);
		end
		for (int n = 0; n < 950; n++) begin
			if (n == 320) begin
				send_idle = 72;
				recv_idle = 10;
			end else if (n == 640) begin
				send_idle = 0;
				recv_idle = 0;
			end
			if ($urandom_range(0, 9) == 0) begin
				m.k[0] = rand_inset();
				foreach (v[i])
					v[i] = 500 + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 2) - 1);
			end else
				foreach (v[i])
					v[i] = rand_inset();
			send_word(v, solve_keystone(v));
		end
		in_valid <= 0;

		waited = 0;
		while (pending_matrices.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (60) @(posedge clk);
		if (mismatches == 0 && pending_matrices.size() == 0)
			$display("tb_keystone_homography_matrix_top passed");
		else
			$display("tb_keystone_homography_matrix_top failed");
		$finish;
	end

endmodule
